@@ rtl/core/lrt_pkg.sv @@
`default_nettype none
package lrt_pkg;
    localparam int MaxLinksDef   = 16;
    localparam int PathBitsDef   = 32;
    localparam int ValueBitsDef  = 32;
    localparam int AllLinksIdDef = 255;

    localparam logic [1:0] CMD_SET    = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_DELIV  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_SHIFT = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [5:0] rd_idx;
        logic [1:0] op;
        logic [5:0] wr_idx;
    } t_cmd;

    typedef struct packed {
        logic       id_hit;
        logic       src_hit;
        logic       dst_hit;
        logic [6:0] count;
    } t_stat;
endpackage
`default_nettype wire

@@ rtl/core/lrt_datapath.sv @@
`default_nettype none
module lrt_datapath
    import lrt_pkg::*;
#(
    parameter int MAX_LINKS = MaxLinksDef,
    parameter int PATH_BITS = PathBitsDef
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    input  wire logic [7:0]           i_link_id,
    input  wire logic [PATH_BITS+23:0] i_src,
    input  wire logic [PATH_BITS+23:0] i_dst,
    output t_stat                     o_stat,
    output logic [PATH_BITS+23:0]     o_rd_dst
);
    localparam int RW = PATH_BITS + 24;
    localparam int IW = $clog2(MAX_LINKS + 1);
    localparam int AW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

    logic [7:0]    mem_id  [MAX_LINKS];
    logic [RW-1:0] mem_src [MAX_LINKS];
    logic [RW-1:0] mem_dst [MAX_LINKS];

    logic [7:0]    r_id;
    logic [RW-1:0] r_src, r_dst;
    logic [IW-1:0] r_count, n_count;
    logic [7:0]    r_rd_id;
    logic [RW-1:0] r_rd_src, r_rd_dst;
    logic [IW-1:0] ri, wi;
    logic [AW-1:0] ra, wa;

    assign ri = i_cmd.rd_idx[IW-1:0];
    assign wi = i_cmd.wr_idx[IW-1:0];
    assign ra = ri[AW-1:0];
    assign wa = wi[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id  <= i_link_id;
            r_src <= i_src;
            r_dst <= i_dst;
        end
        if (i_cmd.rd_en && ri < IW'(MAX_LINKS)) begin
            r_rd_id  <= mem_id[ra];
            r_rd_src <= mem_src[ra];
            r_rd_dst <= mem_dst[ra];
        end
        if (i_cmd.op == OP_WRITE && wi < IW'(MAX_LINKS)) begin
            mem_id[wa]  <= r_id;
            mem_src[wa] <= r_src;
            mem_dst[wa] <= r_dst;
        end else if (i_cmd.op == OP_SHIFT && wi < IW'(MAX_LINKS)) begin
            mem_id[wa]  <= r_rd_id;
            mem_src[wa] <= r_rd_src;
            mem_dst[wa] <= r_rd_dst;
        end
    end

    always_comb begin
        n_count = r_count;
        case (i_cmd.op)
            OP_WRITE: if (wi == r_count) n_count = r_count + 1'b1;
            OP_SHIFT: n_count = r_count;
            OP_RESET: n_count = '0;
            default:  n_count = r_count;
        endcase
        if (i_cmd.op == OP_RESET && i_cmd.wr_idx[0]) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.id_hit  = (r_rd_id == r_id);
    assign o_stat.src_hit = (r_rd_src == r_src);
    assign o_stat.dst_hit = (r_rd_dst == r_dst);
    assign o_stat.count   = 7'(r_count);
    assign o_rd_dst       = r_rd_dst;
endmodule
`default_nettype wire

@@ rtl/core/lrt_ctrl.sv @@
`default_nettype none
module lrt_ctrl
    import lrt_pkg::*;
#(
    parameter int MAX_LINKS    = MaxLinksDef,
    parameter int ALL_LINKS_ID = AllLinksIdDef
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_link_id,
    output t_cmd            o_cmd,
    input  wire t_stat      i_stat,
    output logic            o_emit,
    output logic            o_kind,
    output logic [1:0]      o_status,
    output logic [4:0]      o_fired,
    input  wire logic       i_out_busy
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_SHFT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_DLV  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_op, n_op;
    logic [6:0] r_i, n_i;
    logic [6:0] r_hit, n_hit;
    logic       r_found, n_found;
    logic       r_busy, n_busy;
    logic [1:0] r_st, n_st;
    logic [4:0] r_fired, n_fired;
    logic [6:0] cnt, prev;
    logic       acc;

    assign cnt     = i_stat.count;
    assign prev    = r_i - 7'd1;
    assign o_stall = (r_state != S_IDLE);
    assign acc     = i_valid && !o_stall;

    always_comb begin
        n_state = r_state; n_op = r_op; n_i = r_i; n_hit = r_hit;
        n_found = r_found; n_busy = r_busy; n_st = r_st; n_fired = r_fired;
        o_cmd = '0; o_emit = 1'b0; o_kind = 1'b0; o_status = r_st; o_fired = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = acc; o_cmd.rd_en = acc;
                if (acc) begin
                    n_op = i_cmd; n_i = 7'd1; n_found = 1'b0; n_busy = 1'b0;
                    n_fired = '0; n_st = ST_OK;
                    if (i_cmd == CMD_SET && i_link_id >= 8'(MAX_LINKS)) begin
                        n_st = ST_BAD; n_state = S_DONE;
                    end else if (i_cmd == CMD_UNUSED) begin
                        n_st = ST_BAD; n_state = S_DONE;
                    end else if (i_cmd == CMD_CLEAR && i_link_id == 8'(ALL_LINKS_ID)) begin
                        o_cmd.op = OP_RESET; n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (prev >= cnt) begin
                    n_state = S_CHK;
                end else begin
                    if (r_op == CMD_DELIV && i_stat.src_hit) begin
                        o_emit = 1'b1; o_kind = 1'b1;
                    end
                    if (!(o_emit && i_out_busy)) begin
                        if (r_op == CMD_DELIV && i_stat.src_hit) n_fired = r_fired + 5'd1;
                        if (i_stat.id_hit && !r_found) begin
                            n_found = 1'b1; n_hit = prev;
                        end
                        if (r_op == CMD_SET && !i_stat.id_hit && i_stat.dst_hit)
                            n_busy = 1'b1;
                        o_cmd.rd_en = 1'b1; o_cmd.rd_idx = 6'(r_i); n_i = r_i + 7'd1;
                    end
                end
            end
            S_CHK: begin
                n_state = S_DONE;
                case (r_op)
                    CMD_SET: begin
                        if (r_busy) n_st = ST_BUSY;
                        else if (r_found) begin
                            o_cmd.op = OP_WRITE; o_cmd.wr_idx = 6'(r_hit);
                        end else if (cnt >= 7'(MAX_LINKS)) n_st = ST_FULL;
                        else begin
                            o_cmd.op = OP_WRITE; o_cmd.wr_idx = 6'(cnt);
                        end
                    end
                    CMD_CLEAR: begin
                        if (!r_found) n_st = ST_FULL;
                        else begin
                            n_i = r_hit + 7'd1; o_cmd.rd_en = 1'b1;
                            o_cmd.rd_idx = 6'(r_hit + 7'd1); n_state = S_SHFT;
                        end
                    end
                    default: n_fired = r_fired;
                endcase
            end
            S_SHFT: begin
                if (r_i >= cnt) begin
                    o_cmd.op = OP_RESET; o_cmd.wr_idx = 6'd1; n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_SHIFT; o_cmd.wr_idx = 6'(prev);
                    o_cmd.rd_en = 1'b1; o_cmd.rd_idx = 6'(r_i + 7'd1); n_i = r_i + 7'd1;
                end
            end
            S_DONE: begin
                o_emit = 1'b1; o_fired = r_fired;
                if (!i_out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_op <= '0; r_i <= '0; r_hit <= '0;
            r_found <= 1'b0; r_busy <= 1'b0; r_st <= '0; r_fired <= '0;
        end else begin
            r_state <= n_state; r_op <= n_op; r_i <= n_i; r_hit <= n_hit;
            r_found <= n_found; r_busy <= n_busy; r_st <= n_st; r_fired <= n_fired;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/link_route_table_core.sv @@
`default_nettype none
// Link route table: holds up to MAX_LINKS links (id, source, destination)
// in insertion order.
// Input channel: i_valid/o_stall with one command word (set, clear,
// deliver). Output channel: o_valid/i_stall; each command yields one
// final word (kind 0, last 1) after any delivery words (kind 1).
// Operation: a command scans the table one entry per cycle through the
// entry memory read port, holding while the receiver stalls a delivery
// word; a clear that finds its id then moves each later entry down one
// place. A set with a bad id, the unused command and clear-all skip the
// scan. The final word appears on o_valid in the same cycle that the
// next command can be accepted.
// One command is in work at a time; o_stall is high until its final word
// has been loaded into the output register.
// A delivery word sits in the output register; while the receiver
// stalls the scan holds at that entry, and the final word holds the
// controller until it can be loaded.
// Reset empties the table at once; entry contents are not cleared.
module link_route_table_core
    import lrt_pkg::*;
#(
    parameter int MAX_LINKS    = MaxLinksDef,
    parameter int PATH_BITS    = PathBitsDef,
    parameter int VALUE_BITS   = ValueBitsDef,
    parameter int ALL_LINKS_ID = AllLinksIdDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_link_id,
    input  wire logic [31:0] i_src_path,
    input  wire logic [7:0]  i_src_class,
    input  wire logic [7:0]  i_src_instance,
    input  wire logic [7:0]  i_src_port,
    input  wire logic [31:0] i_dst_path,
    input  wire logic [7:0]  i_dst_class,
    input  wire logic [7:0]  i_dst_instance,
    input  wire logic [7:0]  i_dst_port,
    input  wire logic [31:0] i_payload,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic [1:0]       o_status,
    output logic [31:0]      o_out_path,
    output logic [7:0]       o_out_class,
    output logic [7:0]       o_out_instance,
    output logic [7:0]       o_out_port,
    output logic [31:0]      o_out_value,
    output logic [4:0]       o_fired,
    output logic             o_last
);
    localparam int RW = PATH_BITS + 24;

    t_cmd  cmd;
    t_stat stat;
    logic [RW-1:0] src, dst, rd_dst;
    logic emit, kind, busy;
    logic [1:0] st;
    logic [4:0] fired;
    logic [VALUE_BITS-1:0] r_value;
    logic [63:0] pw_s, pw_d, pw_r, vw;

    assign pw_s = 64'(i_src_path);
    assign pw_d = 64'(i_dst_path);
    assign src  = {pw_s[PATH_BITS-1:0], i_src_class, i_src_instance, i_src_port};
    assign dst  = {pw_d[PATH_BITS-1:0], i_dst_class, i_dst_instance, i_dst_port};
    assign busy = o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) r_value <= VALUE_BITS'(64'(i_payload));
    end

    lrt_datapath #(.MAX_LINKS(MAX_LINKS), .PATH_BITS(PATH_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_link_id(i_link_id),
        .i_src(src), .i_dst(dst), .o_stat(stat), .o_rd_dst(rd_dst)
    );

    lrt_ctrl #(.MAX_LINKS(MAX_LINKS), .ALL_LINKS_ID(ALL_LINKS_ID)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_link_id(i_link_id), .o_cmd(cmd), .i_stat(stat),
        .o_emit(emit), .o_kind(kind), .o_status(st), .o_fired(fired),
        .i_out_busy(busy)
    );

    assign pw_r = 64'(rd_dst[RW-1:24]);
    assign vw   = 64'(r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (!busy) begin
            o_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!busy && emit) begin
            o_kind         <= kind;
            o_status       <= kind ? ST_OK : st;
            o_out_path     <= kind ? pw_r[31:0] : '0;
            o_out_class    <= kind ? rd_dst[23:16] : '0;
            o_out_instance <= kind ? rd_dst[15:8] : '0;
            o_out_port     <= kind ? rd_dst[7:0] : '0;
            o_out_value    <= kind ? vw[31:0] : '0;
            o_fired        <= kind ? 5'd0 : fired;
            o_last         <= !kind;
        end
    end

`ifndef NO_ASSERTIONS
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last != o_kind)) else $error("last and kind disagree");
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= 7'(MAX_LINKS)) else $error("entry count overflow");
    a_deliv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> (o_status == ST_OK && o_fired == 5'd0))
        else $error("delivery word fields");
`endif
endmodule
`default_nettype wire
